// ----- src/chip8_pkg.sv -----
// Shared types, codes and constants of the CHIP-8 core.
// Holds the font glyph table, opcode codes, state encoding and memory request structs.
// No dependencies.
`default_nettype none

package chip8_pkg;

   // Default sizes of the core
   localparam int DEFAULT_MEMORY_BYTES  = 4096;
   localparam int DEFAULT_STACK_DEPTH   = 16;
   localparam int DEFAULT_ENTRY_ADDRESS = 512;

   // Port widths
   localparam int FUNC_BITS     = 3;
   localparam int REQ_DATA_BITS = 56;
   localparam int RSP_DATA_BITS = 80;

   // Display geometry
   localparam int ROW_BITS  = 5;
   localparam int FRAME_ROWS = 32;
   localparam int FRAME_COLS = 64;

   // Register file
   localparam int REG_BITS  = 4;
   localparam int REG_COUNT = 16;

   // Font glyphs live at this address
   localparam logic [11:0] FONT_BASE  = 12'h050;
   localparam int          FONT_BYTES = 80;

   localparam logic [7:0] GLYPHS [FONT_BYTES] = '{
      8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
      8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
      8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
   };

   // Reset content of main memory at one address
   function automatic logic [7:0] font_byte(input logic [11:0] a);
      logic [11:0] off;
      begin
         off = a - FONT_BASE;
         if (a >= FONT_BASE && a < FONT_BASE + 12'(FONT_BYTES)) begin
            return GLYPHS[off[6:0]];
         end
         return 8'h00;
      end
   endfunction

   // Request kinds
   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_LOAD = 3'd0,
      FUNC_EXEC = 3'd1,
      FUNC_TICK = 3'd2,
      FUNC_KEY  = 3'd3,
      FUNC_ROW  = 3'd4
   } func_type;

   // Opcode groups (top nibble)
   localparam logic [3:0] OP_SYS  = 4'h0;
   localparam logic [3:0] OP_JP   = 4'h1;
   localparam logic [3:0] OP_CALL = 4'h2;
   localparam logic [3:0] OP_SEQ  = 4'h3;
   localparam logic [3:0] OP_SNE  = 4'h4;
   localparam logic [3:0] OP_SREQ = 4'h5;
   localparam logic [3:0] OP_LD   = 4'h6;
   localparam logic [3:0] OP_ADD  = 4'h7;
   localparam logic [3:0] OP_ALU  = 4'h8;
   localparam logic [3:0] OP_SRNE = 4'h9;
   localparam logic [3:0] OP_LDI  = 4'hA;
   localparam logic [3:0] OP_JPV0 = 4'hB;
   localparam logic [3:0] OP_RND  = 4'hC;
   localparam logic [3:0] OP_DRAW = 4'hD;
   localparam logic [3:0] OP_KEY  = 4'hE;
   localparam logic [3:0] OP_MISC = 4'hF;

   // ALU functions (low nibble of 8XYN)
   localparam logic [3:0] ALU_MOV = 4'h0;
   localparam logic [3:0] ALU_OR  = 4'h1;
   localparam logic [3:0] ALU_AND = 4'h2;
   localparam logic [3:0] ALU_XOR = 4'h3;
   localparam logic [3:0] ALU_ADD = 4'h4;
   localparam logic [3:0] ALU_SUB = 4'h5;
   localparam logic [3:0] ALU_SHR = 4'h6;
   localparam logic [3:0] ALU_SBN = 4'h7;
   localparam logic [3:0] ALU_SHL = 4'hE;

   // Low byte codes
   localparam logic [7:0] NN_CLS   = 8'hE0;
   localparam logic [7:0] NN_RET   = 8'hEE;
   localparam logic [7:0] NN_SKP   = 8'h9E;
   localparam logic [7:0] NN_SKNP  = 8'hA1;
   localparam logic [7:0] NN_GETDT = 8'h07;
   localparam logic [7:0] NN_WKEY  = 8'h0A;
   localparam logic [7:0] NN_SETDT = 8'h15;
   localparam logic [7:0] NN_SETST = 8'h18;
   localparam logic [7:0] NN_ADDI  = 8'h1E;
   localparam logic [7:0] NN_FONT  = 8'h29;
   localparam logic [7:0] NN_BCD   = 8'h33;
   localparam logic [7:0] NN_STORE = 8'h55;
   localparam logic [7:0] NN_LOAD  = 8'h65;

   // Sequencer states
   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_FETCH_HI,
      S_FETCH_LO,
      S_READ_X,
      S_READ_Y,
      S_EXEC,
      S_SET_VF,
      S_DRAW_RD,
      S_DRAW_WR,
      S_BCD,
      S_STORE_RD,
      S_STORE_WR,
      S_LOAD_RD,
      S_LOAD_WR,
      S_ROW,
      S_DONE
   } state_type;

   // Frame buffer access
   typedef struct packed {
      logic                  clear;
      logic                  wr_en;
      logic [ROW_BITS-1:0]   wr_row;
      logic [FRAME_COLS-1:0] wr_data;
      logic [ROW_BITS-1:0]   rd_row;
   } frame_req_type;

   // Register file access
   typedef struct packed {
      logic                wr_en;
      logic [REG_BITS-1:0] wr_addr;
      logic [7:0]          wr_data;
      logic [REG_BITS-1:0] rd_addr;
   } reg_req_type;

endpackage

`default_nettype wire

// ----- src/chip8_main_mem.sv -----
// Main byte memory of the CHIP-8 core: one write and one registered read port.
// Runs a fill pass after reset that loads the font and zeroes the rest.
// Depends on chip8_pkg.
`default_nettype none

module chip8_main_mem
   import chip8_pkg::*;
#(
   parameter int MEMORY_BYTES = DEFAULT_MEMORY_BYTES
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [$clog2(MEMORY_BYTES)-1:0] rd_addr,
   input  wire logic                            wr_en,
   input  wire logic [$clog2(MEMORY_BYTES)-1:0] wr_addr,
   input  wire logic [7:0]                      wr_data,
   output logic      [7:0]                      rd_data,
   output logic                                 busy
);

   localparam int AW = $clog2(MEMORY_BYTES);

   logic [7:0]    mem [MEMORY_BYTES];
   logic [AW-1:0] fill_ff, fill_in;
   logic          busy_ff, busy_in;
   logic          we;
   logic [AW-1:0] wa;
   logic [7:0]    wd;

   // Advance the fill pointer until the last address is written
   always_comb begin
      fill_in = fill_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         fill_in = fill_ff + 1'b1;
         if (fill_ff == AW'(MEMORY_BYTES - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         busy_ff <= 1'b1;
      end else begin
         fill_ff <= fill_in;
         busy_ff <= busy_in;
      end
   end

   // Fill pass owns the write port while busy
   always_comb begin
      we = wr_en;
      wa = wr_addr;
      wd = wr_data;
      if (busy_ff) begin
         we = 1'b1;
         wa = fill_ff;
         wd = font_byte(12'(fill_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_data <= mem[rd_addr];
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

// ----- src/chip8_frame_mem.sv -----
// Display frame buffer: 32 rows of 64 pixels with a valid bit per row.
// A cleared or never written row reads as zero; read data is registered.
// Depends on chip8_pkg.
`default_nettype none

module chip8_frame_mem
   import chip8_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire frame_req_type         req,
   output logic [FRAME_COLS-1:0]      rd_data
);

   logic [FRAME_COLS-1:0] rows [FRAME_ROWS];
   logic [FRAME_ROWS-1:0] valid_ff, valid_in;

   // Drop all rows on clear, mark a row on write
   always_comb begin
      valid_in = valid_ff;
      if (req.clear) begin
         valid_in = '0;
      end else if (req.wr_en) begin
         valid_in[req.wr_row] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         rows[req.wr_row] <= req.wr_data;
      end
      rd_data <= valid_ff[req.rd_row] ? rows[req.rd_row] : '0;
   end

endmodule

`default_nettype wire

// ----- src/chip8_reg_file.sv -----
// Register file V0..VF with one write and one registered read port.
// Per-entry valid bits give the all-zero reset value.
// Depends on chip8_pkg.
`default_nettype none

module chip8_reg_file
   import chip8_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire reg_req_type req,
   output logic [7:0]       rd_data
);

   logic [7:0]           regs [REG_COUNT];
   logic [REG_COUNT-1:0] valid_ff, valid_in;

   // Mark an entry once written
   always_comb begin
      valid_in = valid_ff;
      if (req.wr_en) begin
         valid_in[req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         regs[req.wr_addr] <= req.wr_data;
      end
      rd_data <= valid_ff[req.rd_addr] ? regs[req.rd_addr] : 8'h00;
   end

endmodule

`default_nettype wire

// ----- src/chip8_cpu_core.sv -----
// CHIP-8 processor core: sequencer, timers, stack and control registers.
// Instantiates chip8_main_mem, chip8_frame_mem and chip8_reg_file; uses chip8_pkg.
//
// Usage: one request enters on req_* (tuser selects the kind: load byte, execute,
// timer tick, key press, read row) and exactly one response leaves on rsp_*.
// The core handles one request at a time; a finished response sits in an output
// register, so a new request is taken while it waits for rsp_tready.
// The sequencer steps through registered main memory and register file reads:
// load, tick, key press, unknown kinds and an execute while waiting for a key go
// straight to the response; read row reads the frame buffer; execute fetches two
// opcode bytes, reads VX and VY, then adds a read and write per DXYN row, three BCD
// digit writes or a read and write per FX55/FX65 register; any VF write is last.
// The core is ready for a new request in the cycle after the response is loaded.
// Reset: a fill pass writes the font and zeroes main memory, one byte a cycle;
// req_tready stays low until it ends. Registers, display, timers and stack level
// clear at once; the program counter starts at ENTRY_ADDRESS.
// Stall: a response held by rsp_tready low keeps the sequencer in its last step
// until the output register frees.
`default_nettype none

module chip8_cpu_core
   import chip8_pkg::*;
#(
   parameter int MEMORY_BYTES  = DEFAULT_MEMORY_BYTES,
   parameter int STACK_DEPTH   = DEFAULT_STACK_DEPTH,
   parameter int ENTRY_ADDRESS = DEFAULT_ENTRY_ADDRESS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // address[11:0], data_byte[19:12], keys_down[35:20], random_byte[43:36],
   // key_value[47:44], display_row[52:48], zero fill
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   // func[2:0]
   input  wire logic [FUNC_BITS-1:0]     req_tuser,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // screen_changed[0], sound_on[1], waiting_for_key[2], row_pixels[66:3],
   // program_counter[78:67], zero fill
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata
);

   localparam int AW  = $clog2(MEMORY_BYTES);
   localparam int SLW = $clog2(STACK_DEPTH + 1);
   localparam int SIW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   // Wrap a 12-bit address into the memory size
   function automatic logic [AW-1:0] mem_at(input logic [11:0] a);
      logic [14:0] v;
      begin
         v = {3'b000, a};
         for (int k = 2; k >= 0; k--) begin
            if (v >= (15'(MEMORY_BYTES) << k)) begin
               v = v - (15'(MEMORY_BYTES) << k);
            end
         end
         return v[AW-1:0];
      end
   endfunction

   // Decimal digits of a byte, hundreds in the top nibble
   function automatic logic [11:0] bcd(input logic [7:0] v);
      logic [7:0] r;
      logic [3:0] h, t;
      begin
         r = v;
         h = 4'd0;
         t = 4'd0;
         if (r >= 8'd200) begin
            r = r - 8'd200;
            h = 4'd2;
         end else if (r >= 8'd100) begin
            r = r - 8'd100;
            h = 4'd1;
         end
         if (r >= 8'd80) begin r = r - 8'd80; t = t + 4'd8; end
         if (r >= 8'd40) begin r = r - 8'd40; t = t + 4'd4; end
         if (r >= 8'd20) begin r = r - 8'd20; t = t + 4'd2; end
         if (r >= 8'd10) begin r = r - 8'd10; t = t + 4'd1; end
         return {h, t, r[3:0]};
      end
   endfunction

   state_type state_ff, state_in;

   logic [FUNC_BITS-1:0] func_ff, func_in;
   logic [11:0]          addr_ff, addr_in;
   logic [7:0]           byte_ff, byte_in;
   logic [15:0]          keys_ff, keys_in;
   logic [7:0]           rnd_ff, rnd_in;
   logic [3:0]           keyv_ff, keyv_in;
   logic [ROW_BITS-1:0]  rsel_ff, rsel_in;

   logic [7:0]            op_hi_ff, op_hi_in;
   logic [15:0]           op_ff, op_in;
   logic [7:0]            vx_ff, vx_in;
   logic [7:0]            vb_ff, vb_in;
   logic [11:0]           pc_ff, pc_in;
   logic [11:0]           i_ff, i_in;
   logic [SLW-1:0]        level_ff, level_in;
   logic [7:0]            dt_ff, dt_in;
   logic [7:0]            st_ff, st_in;
   logic                  kwait_ff, kwait_in;
   logic [3:0]            ktgt_ff, ktgt_in;
   logic [3:0]            cnt_ff, cnt_in;
   logic                  vf_ff, vf_in;
   logic                  changed_ff, changed_in;
   logic [FRAME_COLS-1:0] row_ff, row_in;
   logic [11:0]           bcd_ff, bcd_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic [11:0] stack_ff [STACK_DEPTH];
   logic           stack_we;
   logic [SIW-1:0] stack_idx;

   logic [AW-1:0] mem_rd_addr, mem_wr_addr;
   logic          mem_we;
   logic [7:0]    mem_wr_data, mem_rd_data;
   logic          mem_busy;

   frame_req_type         fr;
   logic [FRAME_COLS-1:0] frame_rd_data;
   reg_req_type           rf;
   logic [7:0]            rf_rd_data;

   logic       accept, load_rsp;
   logic [3:0] nib, ox, oy, on;
   logic [7:0] nn;
   logic [11:0] nnn, pc_plus2, pc_plus4;
   logic [SLW-1:0] level_dec;
   logic [ROW_BITS-1:0] draw_row;
   logic [FRAME_COLS-1:0] sprite_mask;
   logic [2*FRAME_COLS-1:0] sprite_rot;
   logic [8:0] sum9;
   logic       key_hit;
   logic [3:0] bcd_digit;

   chip8_main_mem #(.MEMORY_BYTES(MEMORY_BYTES)) u_main_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (mem_rd_addr),
      .wr_en   (mem_we),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data),
      .busy    (mem_busy)
   );

   chip8_frame_mem u_frame_mem (
      .clock   (clock),
      .reset   (reset),
      .req     (fr),
      .rd_data (frame_rd_data)
   );

   chip8_reg_file u_reg_file (
      .clock   (clock),
      .reset   (reset),
      .req     (rf),
      .rd_data (rf_rd_data)
   );

   // Decode the latched opcode
   assign nib       = op_ff[15:12];
   assign ox        = op_ff[11:8];
   assign oy        = op_ff[7:4];
   assign on        = op_ff[3:0];
   assign nn        = op_ff[7:0];
   assign nnn       = op_ff[11:0];
   assign pc_plus2  = pc_ff + 12'd2;
   assign pc_plus4  = pc_ff + 12'd4;
   assign level_dec = level_ff - 1'b1;
   assign draw_row  = vb_ff[ROW_BITS-1:0] + ROW_BITS'(cnt_ff);
   assign sprite_rot = {mem_rd_data, 56'd0, mem_rd_data, 56'd0} >> vx_ff[5:0];
   assign sprite_mask = sprite_rot[FRAME_COLS-1:0];
   assign key_hit   = (vx_ff < 8'd16) && keys_ff[vx_ff[3:0]];
   assign bcd_digit = (cnt_ff == 4'd0) ? bcd_ff[11:8] :
                      (cnt_ff == 4'd1) ? bcd_ff[7:4] : bcd_ff[3:0];

   assign accept   = req_tvalid && req_tready;
   assign load_rsp = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (!mem_busy) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            case (func_ff)
               FUNC_EXEC: state_in = kwait_ff ? S_DONE : S_FETCH_HI;
               FUNC_ROW:  state_in = S_ROW;
               default:   state_in = S_DONE;
            endcase
         end
         S_FETCH_HI: state_in = S_FETCH_LO;
         S_FETCH_LO: state_in = S_READ_X;
         S_READ_X:   state_in = S_READ_Y;
         S_READ_Y:   state_in = S_EXEC;
         S_EXEC: begin
            state_in = S_DONE;
            case (nib)
               OP_DRAW: state_in = (on == 4'd0) ? S_SET_VF : S_DRAW_RD;
               OP_ALU: begin
                  if (on == ALU_ADD || on == ALU_SUB || on == ALU_SHR ||
                      on == ALU_SBN || on == ALU_SHL) begin
                     state_in = S_SET_VF;
                  end
               end
               OP_MISC: begin
                  if (nn == NN_BCD)        state_in = S_BCD;
                  else if (nn == NN_STORE) state_in = S_STORE_RD;
                  else if (nn == NN_LOAD)  state_in = S_LOAD_RD;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_SET_VF:  state_in = S_DONE;
         S_DRAW_RD: state_in = S_DRAW_WR;
         S_DRAW_WR: begin
            state_in = ({1'b0, cnt_ff} + 5'd1 == {1'b0, on}) ? S_SET_VF : S_DRAW_RD;
         end
         S_BCD: begin
            if (cnt_ff == 4'd2) state_in = S_DONE;
         end
         S_STORE_RD: state_in = S_STORE_WR;
         S_STORE_WR: state_in = (cnt_ff == ox) ? S_DONE : S_STORE_RD;
         S_LOAD_RD:  state_in = S_LOAD_WR;
         S_LOAD_WR:  state_in = (cnt_ff == ox) ? S_DONE : S_LOAD_RD;
         S_ROW:      state_in = S_DONE;
         S_DONE: begin
            if (load_rsp) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and memory control
   always_comb begin
      func_in    = func_ff;
      addr_in    = addr_ff;
      byte_in    = byte_ff;
      keys_in    = keys_ff;
      rnd_in     = rnd_ff;
      keyv_in    = keyv_ff;
      rsel_in    = rsel_ff;
      op_hi_in   = op_hi_ff;
      op_in      = op_ff;
      vx_in      = vx_ff;
      vb_in      = vb_ff;
      pc_in      = pc_ff;
      i_in       = i_ff;
      level_in   = level_ff;
      dt_in      = dt_ff;
      st_in      = st_ff;
      kwait_in   = kwait_ff;
      ktgt_in    = ktgt_ff;
      cnt_in     = cnt_ff;
      vf_in      = vf_ff;
      changed_in = changed_ff;
      row_in     = row_ff;
      bcd_in     = bcd_ff;
      sum9       = 9'd0;

      stack_we   = 1'b0;
      stack_idx  = level_ff[SIW-1:0];

      mem_rd_addr = mem_at(pc_ff);
      mem_we      = 1'b0;
      mem_wr_addr = mem_at(addr_ff);
      mem_wr_data = byte_ff;

      fr.clear   = 1'b0;
      fr.wr_en   = 1'b0;
      fr.wr_row  = draw_row;
      fr.wr_data = frame_rd_data ^ sprite_mask;
      fr.rd_row  = draw_row;

      rf.wr_en   = 1'b0;
      rf.wr_addr = ox;
      rf.wr_data = 8'h00;
      rf.rd_addr = op_hi_ff[3:0];

      case (state_ff)
         S_IDLE: begin
            // Latch the request
            if (accept) begin
               func_in    = req_tuser;
               addr_in    = req_tdata[11:0];
               byte_in    = req_tdata[19:12];
               keys_in    = req_tdata[35:20];
               rnd_in     = req_tdata[43:36];
               keyv_in    = req_tdata[47:44];
               rsel_in    = req_tdata[52:48];
               changed_in = 1'b0;
               row_in     = '0;
            end
         end
         S_DISPATCH: begin
            fr.rd_row = rsel_ff;
            case (func_ff)
               FUNC_LOAD: begin
                  mem_we = 1'b1;
               end
               FUNC_TICK: begin
                  if (dt_ff != 8'd0) dt_in = dt_ff - 8'd1;
                  if (st_ff != 8'd0) st_in = st_ff - 8'd1;
               end
               FUNC_KEY: begin
                  if (kwait_ff) begin
                     rf.wr_en   = 1'b1;
                     rf.wr_addr = ktgt_ff;
                     rf.wr_data = {4'd0, keyv_ff};
                     kwait_in   = 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end
         S_FETCH_HI: begin
            op_hi_in    = mem_rd_data;
            mem_rd_addr = mem_at(pc_ff + 12'd1);
         end
         S_FETCH_LO: begin
            op_in      = {op_hi_ff, mem_rd_data};
            rf.rd_addr = op_hi_ff[3:0];
         end
         S_READ_X: begin
            vx_in      = rf_rd_data;
            rf.rd_addr = (nib == OP_JPV0) ? 4'd0 : oy;
         end
         S_READ_Y: begin
            vb_in = rf_rd_data;
         end
         S_EXEC: begin
            pc_in  = pc_plus2;
            cnt_in = 4'd0;
            case (nib)
               OP_SYS: begin
                  if (nn == NN_CLS) begin
                     fr.clear   = 1'b1;
                     changed_in = 1'b1;
                  end else if (nn == NN_RET && level_ff != '0) begin
                     level_in  = level_dec;
                     pc_in     = stack_ff[level_dec[SIW-1:0]];
                  end
               end
               OP_JP: pc_in = nnn;
               OP_CALL: begin
                  if (level_ff < SLW'(STACK_DEPTH)) begin
                     stack_we = 1'b1;
                     level_in = level_ff + 1'b1;
                     pc_in    = nnn;
                  end
               end
               OP_SEQ:  if (vx_ff == nn) pc_in = pc_plus4;
               OP_SNE:  if (vx_ff != nn) pc_in = pc_plus4;
               OP_SREQ: if (on == 4'd0 && vx_ff == vb_ff) pc_in = pc_plus4;
               OP_SRNE: if (on == 4'd0 && vx_ff != vb_ff) pc_in = pc_plus4;
               OP_LD: begin
                  rf.wr_en   = 1'b1;
                  rf.wr_data = nn;
               end
               OP_ADD: begin
                  rf.wr_en   = 1'b1;
                  rf.wr_data = vx_ff + nn;
               end
               OP_ALU: begin
                  rf.wr_en = 1'b1;
                  case (on)
                     ALU_MOV: rf.wr_data = vb_ff;
                     ALU_OR:  rf.wr_data = vx_ff | vb_ff;
                     ALU_AND: rf.wr_data = vx_ff & vb_ff;
                     ALU_XOR: rf.wr_data = vx_ff ^ vb_ff;
                     ALU_ADD: begin
                        sum9       = {1'b0, vx_ff} + {1'b0, vb_ff};
                        rf.wr_data = sum9[7:0];
                        vf_in      = sum9[8];
                     end
                     ALU_SUB: begin
                        rf.wr_data = vx_ff - vb_ff;
                        vf_in      = vx_ff >= vb_ff;
                     end
                     ALU_SHR: begin
                        rf.wr_data = {1'b0, vx_ff[7:1]};
                        vf_in      = vx_ff[0];
                     end
                     ALU_SBN: begin
                        rf.wr_data = vb_ff - vx_ff;
                        vf_in      = vb_ff >= vx_ff;
                     end
                     ALU_SHL: begin
                        rf.wr_data = {vx_ff[6:0], 1'b0};
                        vf_in      = vx_ff[7];
                     end
                     default: rf.wr_en = 1'b0;
                  endcase
               end
               OP_LDI:  i_in  = nnn;
               OP_JPV0: pc_in = nnn + {4'd0, vb_ff};
               OP_RND: begin
                  rf.wr_en   = 1'b1;
                  rf.wr_data = rnd_ff & nn;
               end
               OP_DRAW: begin
                  vf_in      = 1'b0;
                  changed_in = 1'b1;
               end
               OP_KEY: begin
                  if (nn == NN_SKP && key_hit)        pc_in = pc_plus4;
                  else if (nn == NN_SKNP && !key_hit) pc_in = pc_plus4;
               end
               OP_MISC: begin
                  case (nn)
                     NN_GETDT: begin
                        rf.wr_en   = 1'b1;
                        rf.wr_data = dt_ff;
                     end
                     NN_WKEY: begin
                        kwait_in = 1'b1;
                        ktgt_in  = ox;
                     end
                     NN_SETDT: dt_in = vx_ff;
                     NN_SETST: st_in = vx_ff;
                     NN_ADDI:  i_in  = i_ff + {4'd0, vx_ff};
                     NN_FONT:  i_in  = FONT_BASE + 12'(vx_ff[3:0]) * 12'd5;
                     NN_BCD:   bcd_in = bcd(vx_ff);
                     default: begin
                     end
                  endcase
               end
               default: begin
               end
            endcase
         end
         S_SET_VF: begin
            rf.wr_en   = 1'b1;
            rf.wr_addr = 4'hF;
            rf.wr_data = {7'd0, vf_ff};
         end
         S_DRAW_RD: begin
            mem_rd_addr = mem_at(i_ff + 12'(cnt_ff));
         end
         S_DRAW_WR: begin
            // Flip the sprite row, note any pixel turned off
            fr.wr_en = 1'b1;
            if ((frame_rd_data & sprite_mask) != '0) vf_in = 1'b1;
            cnt_in = cnt_ff + 4'd1;
         end
         S_BCD: begin
            mem_we      = 1'b1;
            mem_wr_addr = mem_at(i_ff + 12'(cnt_ff));
            mem_wr_data = {4'd0, bcd_digit};
            cnt_in      = cnt_ff + 4'd1;
         end
         S_STORE_RD: begin
            rf.rd_addr = cnt_ff;
         end
         S_STORE_WR: begin
            mem_we      = 1'b1;
            mem_wr_addr = mem_at(i_ff + 12'(cnt_ff));
            mem_wr_data = rf_rd_data;
            cnt_in      = cnt_ff + 4'd1;
         end
         S_LOAD_RD: begin
            mem_rd_addr = mem_at(i_ff + 12'(cnt_ff));
         end
         S_LOAD_WR: begin
            rf.wr_en   = 1'b1;
            rf.wr_addr = cnt_ff;
            rf.wr_data = mem_rd_data;
            cnt_in     = cnt_ff + 4'd1;
         end
         S_ROW: begin
            row_in = frame_rd_data;
         end
         default: begin
         end
      endcase
   end

   // Output register: load on finish, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, pc_ff, row_ff, kwait_ff, (st_ff != 8'd0), changed_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         pc_ff        <= 12'(ENTRY_ADDRESS);
         i_ff         <= '0;
         level_ff     <= '0;
         dt_ff        <= '0;
         st_ff        <= '0;
         kwait_ff     <= 1'b0;
         ktgt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         i_ff         <= i_in;
         level_ff     <= level_in;
         dt_ff        <= dt_in;
         st_ff        <= st_in;
         kwait_ff     <= kwait_in;
         ktgt_ff      <= ktgt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      addr_ff     <= addr_in;
      byte_ff     <= byte_in;
      keys_ff     <= keys_in;
      rnd_ff      <= rnd_in;
      keyv_ff     <= keyv_in;
      rsel_ff     <= rsel_in;
      op_hi_ff    <= op_hi_in;
      op_ff       <= op_in;
      vx_ff       <= vx_in;
      vb_ff       <= vb_in;
      cnt_ff      <= cnt_in;
      vf_ff       <= vf_in;
      changed_ff  <= changed_in;
      row_ff      <= row_in;
      bcd_ff      <= bcd_in;
      rsp_data_ff <= rsp_data_in;
      if (stack_we) begin
         stack_ff[stack_idx] <= pc_plus2;
      end
   end

endmodule

`default_nettype wire

// ----- src/chip8_checker.sv -----
// Port-level checks of the CHIP-8 core and the bind that attaches them.
// Depends on chip8_pkg and chip8_cpu_core.
`default_nettype none

module chip8_checker
   import chip8_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_tvalid,
   input wire logic                     req_tready,
   input wire logic                     rsp_tvalid,
   input wire logic                     rsp_tready,
   input wire logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Reset leaves no response pending
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // One request at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // A waiting core has not drawn
   a_wait_no_draw: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> !rsp_tdata[0])
      else $error("screen change reported while waiting for key");

endmodule

bind chip8_cpu_core chip8_checker u_checker (.*);

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench of chip8_cpu_core: directed table, then random programs.
// A predictor of the CPU state forecasts every response; needs chip8_pkg and the core.
`default_nettype none

module testbench;
   import chip8_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int       CYCLE_LIMIT = 600000;
   localparam int       RANDOM_REQS = 900;
   localparam func_type FUNC_SPARE  = func_type'(3'd7);

   // One response, as the predictor forecasts it
   typedef struct packed {
      logic        changed;
      logic        sound;
      logic        waiting;
      logic [63:0] row;
      logic [11:0] pc;
   } status_type;

   // One row of the directed table
   typedef struct packed {
      logic [2:0]  func;
      logic [11:0] addr;
      logic [7:0]  dat;
      logic [15:0] keys;
      logic [7:0]  rnd;
      logic [3:0]  kval;
      logic [4:0]  drow;
      logic        fixed;
      status_type  want;
   } stim_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [FUNC_BITS-1:0]     req_tuser = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   chip8_cpu_core u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   // Predicted CPU state
   logic [7:0]  mem [4096];
   logic [63:0] frame [32];
   logic [7:0]  vreg [16];
   logic [11:0] ireg, pc;
   logic [11:0] stack [16];
   int          level;
   logic [7:0]  delay_tmr, sound_tmr;
   logic        key_wait;
   logic [3:0]  key_dst;

   status_type  status_queue [$];
   int          errors = 0;
   int          cycles = 0;
   bit          no_gaps = 1'b0;
   bit          burst_done = 1'b0;
   int          sent = 0;

   // Fail on a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Skip the next instruction when the condition holds
   function automatic void skip_when(input bit c);
      if (c) pc = pc + 12'd2;
   endfunction

   // Execute one instruction at pc; returns one if the display was touched
   function automatic bit exec_instr(input logic [15:0] keys, input logic [7:0] rnd);
      logic [15:0] op;
      logic [11:0] nnn, ad;
      logic [7:0]  nn, va, vb, bits;
      logic [3:0]  n, x, y;
      logic [8:0]  sum;
      logic        hit;
      int          px, py, r, c, col, rw, i;
      bit          pressed;
      op  = {mem[pc], mem[pc + 12'd1]};
      nnn = op[11:0];
      nn  = op[7:0];
      n   = op[3:0];
      x   = op[11:8];
      y   = op[7:4];
      pc  = pc + 12'd2;
      case (op[15:12])
         OP_SYS: begin
            if (nn == NN_CLS) begin
               foreach (frame[k]) frame[k] = '0;
               return 1'b1;
            end
            if (nn == NN_RET && level > 0) begin
               level--;
               pc = stack[level];
            end
         end
         OP_JP: pc = nnn;
         OP_CALL: begin
            if (level < 16) begin
               stack[level] = pc;
               level++;
               pc = nnn;
            end
         end
         OP_SEQ:  skip_when(vreg[x] == nn);
         OP_SNE:  skip_when(vreg[x] != nn);
         OP_SREQ: skip_when(n == 4'd0 && vreg[x] == vreg[y]);
         OP_LD:   vreg[x] = nn;
         OP_ADD:  vreg[x] = vreg[x] + nn;
         OP_ALU: begin
            va = vreg[x];
            vb = vreg[y];
            // flag goes in after the result, so VF as target keeps the flag
            case (n)
               ALU_MOV: vreg[x] = vb;
               ALU_OR:  vreg[x] = va | vb;
               ALU_AND: vreg[x] = va & vb;
               ALU_XOR: vreg[x] = va ^ vb;
               ALU_ADD: begin
                  sum = {1'b0, va} + {1'b0, vb};
                  vreg[x] = sum[7:0];
                  vreg[15] = {7'd0, sum[8]};
               end
               ALU_SUB: begin
                  vreg[x] = va - vb;
                  vreg[15] = {7'd0, va >= vb};
               end
               ALU_SHR: begin
                  vreg[x] = va >> 1;
                  vreg[15] = {7'd0, va[0]};
               end
               ALU_SBN: begin
                  vreg[x] = vb - va;
                  vreg[15] = {7'd0, vb >= va};
               end
               ALU_SHL: begin
                  vreg[x] = va << 1;
                  vreg[15] = {7'd0, va[7]};
               end
               default: ;
            endcase
         end
         OP_SRNE: skip_when(n == 4'd0 && vreg[x] != vreg[y]);
         OP_LDI:  ireg = nnn;
         OP_JPV0: pc = nnn + {4'd0, vreg[0]};
         OP_RND:  vreg[x] = rnd & nn;
         OP_DRAW: begin
            px  = int'(vreg[x]) & 63;
            py  = int'(vreg[y]) & 31;
            hit = 1'b0;
            for (r = 0; r < int'(n); r++) begin
               ad   = ireg + 12'(r);
               bits = mem[ad];
               rw   = (py + r) & 31;
               for (c = 0; c < 8; c++) begin
                  if (bits[7 - c]) begin
                     col = (px + c) & 63;
                     if (frame[rw][63 - col]) hit = 1'b1;
                     frame[rw][63 - col] = ~frame[rw][63 - col];
                  end
               end
            end
            vreg[15] = {7'd0, hit};
            return 1'b1;
         end
         OP_KEY: begin
            pressed = vreg[x] < 8'd16 && keys[vreg[x][3:0]];
            if (nn == NN_SKP) skip_when(pressed);
            else if (nn == NN_SKNP) skip_when(!pressed);
         end
         default: begin
            case (nn)
               NN_GETDT: vreg[x] = delay_tmr;
               NN_WKEY: begin
                  key_wait = 1'b1;
                  key_dst  = x;
               end
               NN_SETDT: delay_tmr = vreg[x];
               NN_SETST: sound_tmr = vreg[x];
               NN_ADDI:  ireg = ireg + {4'd0, vreg[x]};
               NN_FONT:  ireg = FONT_BASE + 12'(vreg[x][3:0]) * 12'd5;
               NN_BCD: begin
                  mem[ireg]         = vreg[x] / 8'd100;
                  mem[ireg + 12'd1] = (vreg[x] / 8'd10) % 8'd10;
                  mem[ireg + 12'd2] = vreg[x] % 8'd10;
               end
               NN_STORE: for (i = 0; i <= int'(x); i++) mem[ireg + 12'(i)] = vreg[i];
               NN_LOAD:  for (i = 0; i <= int'(x); i++) vreg[i] = mem[ireg + 12'(i)];
               default: ;
            endcase
         end
      endcase
      return 1'b0;
   endfunction

   // Advance the predicted state by one request and return the response
   function automatic status_type cpu_step(input stim_type q);
      status_type s;
      s = '0;
      case (q.func)
         FUNC_LOAD: mem[q.addr] = q.dat;
         FUNC_EXEC: if (!key_wait) s.changed = exec_instr(q.keys, q.rnd);
         FUNC_TICK: begin
            if (delay_tmr != 8'd0) delay_tmr--;
            if (sound_tmr != 8'd0) sound_tmr--;
         end
         FUNC_KEY: begin
            if (key_wait) begin
               vreg[key_dst] = {4'd0, q.kval};
               key_wait = 1'b0;
            end
         end
         FUNC_ROW: s.row = frame[q.drow];
         default: ;
      endcase
      s.sound   = sound_tmr != 8'd0;
      s.waiting = key_wait;
      s.pc      = pc;
      return s;
   endfunction

   // Queue the expected response and drive one request through the handshake
   task automatic send_req(input stim_type q);
      status_type s;
      int         gap;
      s = cpu_step(q);
      status_queue.push_back(q.fixed ? q.want : s);
      gap = no_gaps ? 0 : $urandom_range(10, 0);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= q.func;
      req_tdata  <= {3'd0, q.drow, q.kval, q.rnd, q.keys, q.dat, q.addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
      if (sent % 60 == 0) no_gaps = ($urandom_range(3, 0) == 0);
   endtask

   // Random request of the given kind with random content
   function automatic stim_type rand_req(input logic [2:0] f);
      stim_type q;
      q      = '0;
      q.func = f;
      q.addr = 12'($urandom);
      q.dat  = 8'($urandom);
      q.keys = 16'($urandom);
      q.rnd  = 8'($urandom);
      q.kval = 4'($urandom);
      q.drow = 5'($urandom);
      return q;
   endfunction

   // Random instruction, biased toward defined codes
   function automatic logic [15:0] rand_op();
      logic [15:0] op;
      logic [7:0]  fcodes [9];
      logic [3:0]  acodes [9];
      fcodes = '{NN_GETDT, NN_WKEY, NN_SETDT, NN_SETST, NN_ADDI, NN_FONT, NN_BCD,
                 NN_STORE, NN_LOAD};
      acodes = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR, ALU_SBN,
                 ALU_SHL};
      op = 16'($urandom);
      case (op[15:12])
         OP_SYS: begin
            case ($urandom_range(3, 0))
               0: op[11:0] = {4'd0, NN_CLS};
               1, 2: op[11:0] = {4'd0, NN_RET};
               default: ;
            endcase
         end
         OP_JP: if ($urandom_range(9, 0) == 0) op[11:0] = 12'hFFE + 12'($urandom_range(1, 0));
         OP_SREQ, OP_SRNE: if ($urandom_range(1, 0) == 0) op[3:0] = 4'd0;
         OP_ALU: if ($urandom_range(7, 0) != 0) op[3:0] = acodes[$urandom_range(8, 0)];
         OP_KEY: begin
            case ($urandom_range(2, 0))
               0: op[7:0] = NN_SKP;
               1: op[7:0] = NN_SKNP;
               default: ;
            endcase
         end
         OP_MISC: if ($urandom_range(7, 0) != 0) op[7:0] = fcodes[$urandom_range(8, 0)];
         default: ;
      endcase
      return op;
   endfunction

   // Place an instruction at the predicted pc and execute it
   task automatic run_instr(input logic [15:0] op);
      stim_type q;
      q = rand_req(FUNC_LOAD);
      q.addr = pc;
      q.dat  = op[15:8];
      send_req(q);
      q.addr = pc + 12'd1;
      q.dat  = op[7:0];
      send_req(q);
      send_req(rand_req(FUNC_EXEC));
   endtask

   // Compare each response with the oldest expectation
   initial begin
      status_type got, want;
      int         stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = $urandom_range(3, 0) == 0 ? 0 : $urandom_range(10, 0);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         got = '{changed: rsp_tdata[0], sound: rsp_tdata[1], waiting: rsp_tdata[2],
                 row: rsp_tdata[66:3], pc: rsp_tdata[78:67]};
         if (status_queue.size() == 0) begin
            $display("%0t: response with nothing expected, got %h", $time, got);
            errors++;
         end else begin
            want = status_queue.pop_front();
            if (got.changed !== want.changed) begin
               $display("%0t: screen_changed expected %h got %h", $time, want.changed,
                        got.changed);
               errors++;
            end
            if (got.sound !== want.sound) begin
               $display("%0t: sound_on expected %h got %h", $time, want.sound, got.sound);
               errors++;
            end
            if (got.waiting !== want.waiting) begin
               $display("%0t: waiting_for_key expected %h got %h", $time, want.waiting,
                        got.waiting);
               errors++;
            end
            if (got.row !== want.row) begin
               $display("%0t: row_pixels expected %h got %h", $time, want.row, got.row);
               errors++;
            end
            if (got.pc !== want.pc) begin
               $display("%0t: program_counter expected %h got %h", $time, want.pc, got.pc);
               errors++;
            end
         end
      end
   end

   // Stimulus: reset, directed table, random programs, drain
   initial begin
      stim_type table_rows [23];
      int       pick, k;
      // typed expectations: {changed, sound, waiting, row, pc}
      table_rows = '{
         '{FUNC_ROW,  12'h000, 8'h00, 16'h0000, 8'h00, 4'h0, 5'd0,  1'b1,
           '{1'b0, 1'b0, 1'b0, 64'd0, 12'h200}},
         '{FUNC_TICK, 12'h000, 8'h00, 16'h0000, 8'h00, 4'h0, 5'd0,  1'b1,
           '{1'b0, 1'b0, 1'b0, 64'd0, 12'h200}},
         // key press while running is dropped
         '{FUNC_KEY,  12'h000, 8'h00, 16'h0000, 8'h00, 4'hF, 5'd0,  1'b1,
           '{1'b0, 1'b0, 1'b0, 64'd0, 12'h200}},
         '{FUNC_LOAD, 12'h200, 8'h00, 16'h0000, 8'h00, 4'h0, 5'd0,  1'b1,
           '{1'b0, 1'b0, 1'b0, 64'd0, 12'h200}},
         '{FUNC_LOAD, 12'h201, 8'hE0, 16'h0000, 8'h00, 4'h0, 5'd0,  1'b0, '0},
         // clear screen
         '{FUNC_EXEC, 12'h000, 8'h00, 16'hFFFF, 8'hFF, 4'h0, 5'd0,  1'b1,
           '{1'b1, 1'b0, 1'b0, 64'd0, 12'h202}},
         '{FUNC_LOAD, 12'h202, 8'h60, 16'h0000, 8'h00, 4'h0, 5'd0,  1'b0, '0},
         '{FUNC_LOAD, 12'h203, 8'hFF, 16'h0000, 8'h00, 4'h0, 5'd0,  1'b0, '0},
         '{FUNC_EXEC, 12'h000, 8'h00, 16'h0000, 8'h00, 4'h0, 5'd0,  1'b0, '0},
         '{FUNC_LOAD, 12'h204, 8'hF0, 16'h0000, 8'h00, 4'h0, 5'd0,  1'b0, '0},
         '{FUNC_LOAD, 12'h205, 8'h18, 16'h0000, 8'h00, 4'h0, 5'd0,  1'b0, '0},
         '{FUNC_EXEC, 12'h000, 8'h00, 16'h0000, 8'h00, 4'h0, 5'd0,  1'b1,
           '{1'b0, 1'b1, 1'b0, 64'd0, 12'h206}},
         // wait for key into VF, then an execute that must stall
         '{FUNC_LOAD, 12'h206, 8'hFF, 16'h0000, 8'h00, 4'h0, 5'd0,  1'b0, '0},
         '{FUNC_LOAD, 12'h207, 8'h0A, 16'h0000, 8'h00, 4'h0, 5'd0,  1'b0, '0},
         '{FUNC_EXEC, 12'h000, 8'h00, 16'h0000, 8'h00, 4'h0, 5'd0,  1'b1,
           '{1'b0, 1'b1, 1'b1, 64'd0, 12'h208}},
         '{FUNC_EXEC, 12'h000, 8'h00, 16'hFFFF, 8'hFF, 4'h0, 5'd0,  1'b1,
           '{1'b0, 1'b1, 1'b1, 64'd0, 12'h208}},
         '{FUNC_KEY,  12'h000, 8'h00, 16'h0000, 8'h00, 4'hF, 5'd0,  1'b1,
           '{1'b0, 1'b1, 1'b0, 64'd0, 12'h208}},
         // return on an empty stack only advances
         '{FUNC_LOAD, 12'h208, 8'h00, 16'h0000, 8'h00, 4'h0, 5'd0,  1'b0, '0},
         '{FUNC_LOAD, 12'h209, 8'hEE, 16'h0000, 8'h00, 4'h0, 5'd0,  1'b0, '0},
         '{FUNC_EXEC, 12'h000, 8'h00, 16'h0000, 8'h00, 4'h0, 5'd0,  1'b1,
           '{1'b0, 1'b1, 1'b0, 64'd0, 12'h20A}},
         '{FUNC_LOAD, 12'hFFF, 8'hFF, 16'h0000, 8'h00, 4'h0, 5'd0,  1'b0, '0},
         '{FUNC_SPARE, 12'h000, 8'h00, 16'h0000, 8'h00, 4'h0, 5'd0, 1'b1,
           '{1'b0, 1'b1, 1'b0, 64'd0, 12'h20A}},
         '{FUNC_ROW,  12'h000, 8'h00, 16'h0000, 8'h00, 4'h0, 5'd31, 1'b1,
           '{1'b0, 1'b1, 1'b0, 64'd0, 12'h20A}}
      };

      // predicted reset state
      foreach (mem[a]) mem[a] = 8'h00;
      foreach (GLYPHS[g]) mem[FONT_BASE + 12'(g)] = GLYPHS[g];
      foreach (frame[r]) frame[r] = '0;
      foreach (vreg[r]) vreg[r] = 8'h00;
      foreach (stack[r]) stack[r] = 12'h000;
      ireg      = 12'h000;
      pc        = 12'(DEFAULT_ENTRY_ADDRESS);
      level     = 0;
      delay_tmr = 8'h00;
      sound_tmr = 8'h00;
      key_wait  = 1'b0;
      key_dst   = 4'h0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (table_rows[r]) send_req(table_rows[r]);

      // random programs with ticks, key presses, row reads and noise mixed in
      while (sent < RANDOM_REQS + 23) begin
         if (sent > 450 && sent < 460) begin
            // hold off until the core has answered everything
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (status_queue.size() != 0) @(posedge clock);
         end
         pick = $urandom_range(99, 0);
         if (key_wait && pick < 50) send_req(rand_req(FUNC_KEY));
         else if (pick < 60) run_instr(rand_op());
         else if (pick < 68) send_req(rand_req(FUNC_TICK));
         else if (pick < 73) send_req(rand_req(FUNC_KEY));
         else if (pick < 81) send_req(rand_req(FUNC_ROW));
         else if (pick < 89) send_req(rand_req(FUNC_LOAD));
         else if (pick < 94) send_req(rand_req(FUNC_EXEC));
         else if (pick < 98) send_req(rand_req(3'($urandom_range(7, 5))));
         else if (!burst_done) begin
            // nest calls past the stack depth, then unwind further than it goes
            burst_done = 1'b1;
            for (k = 0; k < 18; k++) run_instr({OP_CALL, 12'($urandom_range(4095, 768))});
            for (k = 0; k < 18; k++) run_instr({OP_SYS, 4'd0, NN_RET});
         end
      end
      req_tvalid <= 1'b0;

      // drain, then allow the slowest instruction to finish
      @(posedge clock);
      while (status_queue.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- filelist.f -----
src/chip8_pkg.sv
src/chip8_main_mem.sv
src/chip8_frame_mem.sv
src/chip8_reg_file.sv
src/chip8_cpu_core.sv
src/chip8_checker.sv
sim/testbench.sv
